[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk, ignored while rst is high.
`define FFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that post holds in the cycle after pre, ignored while rst is high.
`define FFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/ffr_pkg.sv]
package ffr_pkg;

  localparam int NUM_LINES = 5;

  localparam int FUNC_W   = 2;
  localparam int LINE_W   = 3;
  localparam int LEVEL_W  = 16;
  localparam int DUR_W    = 16;
  localparam int DELTA_W  = 16;
  localparam int FACTOR_W = 25;
  localparam int PROD_W   = FACTOR_W + DELTA_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int DCNT_W   = $clog2(FACTOR_W);
  localparam int IDX_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FACTOR_W-1:0] UNITY_Q24 = FACTOR_W'(1) << (FACTOR_W - 1);
  localparam logic [LEVEL_W-1:0]  UNITY_Q15 = LEVEL_W'(1) << (LEVEL_W - 1);

  typedef logic [IDX_W-1:0] line_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET      = 2'd0,
    FUNC_FADE_IN  = 2'd1,
    FUNC_FADE_OUT = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_IN   = 2'd1,
    MODE_OUT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    B_FETCH,
    B_DIV,
    B_MUL,
    B_ACC,
    B_SCALE,
    B_SEND
  } back_state_t;

  // A classified command: level already saturated, duration already nonzero.
  typedef struct packed {
    func_t               func;
    logic [LINE_W-1:0]   line;
    logic [LEVEL_W-1:0]  level;
    logic [DUR_W-1:0]    duration;
    logic [DELTA_W-1:0]  delta;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

[rtl/core/ffr_if.sv]
interface ffr_in_if;
  logic                         valid;
  logic                         ready;
  logic [ffr_pkg::FUNC_W-1:0]   func;
  logic [ffr_pkg::LINE_W-1:0]   line;
  logic [ffr_pkg::LEVEL_W-1:0]  level;
  logic [ffr_pkg::DUR_W-1:0]    duration;
  logic [ffr_pkg::DELTA_W-1:0]  delta;

  modport source (output valid, func, line, level, duration, delta, input ready);
  modport sink   (input valid, func, line, level, duration, delta, output ready);
endinterface

interface ffr_out_if;
  logic                         valid;
  logic                         ready;
  logic [ffr_pkg::LINE_W-1:0]   out_line;
  logic [ffr_pkg::LEVEL_W-1:0]  out_level;
  logic                         last;

  modport source (output valid, out_line, out_level, last, input ready);
  modport sink   (input valid, out_line, out_level, last, output ready);
endinterface

[rtl/core/multi_line_volume_fade_ramp_top.sv]
// Channel  Interface        Beat
// cmd      ffr_in_if sink   func, line, level, duration, delta
// res      ffr_out_if src   out_line, out_level, last
//
// A fade start runs the one-bit-per-cycle divider that forms the step from
// the duration.
// A tick during a fade does one multiply for the ramp update, then one
// multiply and one output beat per line.
// rst is synchronous; levels reset to unity, the factor to unity, no fade.
// A two-entry command queue keeps taking beats while results stall on res, until it is full.
module multi_line_volume_fade_ramp_top (
  input  logic       clk,
  input  logic       rst,
  ffr_in_if.sink     cmd,
  ffr_out_if.source  res
);

  ffr_pkg::cmd_beat_t  push;
  logic                push_ready;
  ffr_pkg::cmd_beat_t  head;
  logic                pop;

  ffr_front u_front (
    .cmd        (cmd),
    .push       (push),
    .push_ready (push_ready)
  );

  ffr_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  ffr_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

endmodule

[rtl/core/ffr_front.sv]
module ffr_front (
  ffr_in_if.sink              cmd,
  output ffr_pkg::cmd_beat_t  push,
  input  logic                push_ready
);

  logic                         line_ok;
  logic                         keep;
  ffr_pkg::func_t               func;
  logic [ffr_pkg::LEVEL_W-1:0]  level_sat;
  logic [ffr_pkg::DUR_W-1:0]    dur_fix;

  always_comb begin
    func      = ffr_pkg::func_t'(cmd.func);
    line_ok   = 32'(cmd.line) < 32'(ffr_pkg::NUM_LINES);
    // A level write to a line that does not exist is dropped here.
    keep      = (func != ffr_pkg::FUNC_SET) || line_ok;
    level_sat = (cmd.level > ffr_pkg::UNITY_Q15) ? ffr_pkg::UNITY_Q15 : cmd.level;
    dur_fix   = (cmd.duration == '0) ? ffr_pkg::DUR_W'(1) : cmd.duration;
  end

  assign cmd.ready          = push_ready;
  assign push.valid         = cmd.valid && keep;
  assign push.cmd.func      = func;
  assign push.cmd.line      = cmd.line;
  assign push.cmd.level     = level_sat;
  assign push.cmd.duration  = dur_fix;
  assign push.cmd.delta     = cmd.delta;

endmodule

[rtl/core/ffr_cmd_queue.sv]
`include "assert_macros.svh"

module ffr_cmd_queue (
  input  logic                clk,
  input  logic                rst,
  input  ffr_pkg::cmd_beat_t  push,
  output logic                push_ready,
  output ffr_pkg::cmd_beat_t  head,
  input  logic                pop
);

  ffr_pkg::cmd_t               entries [ffr_pkg::QUEUE_DEPTH];
  logic [ffr_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ffr_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ffr_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = count != ffr_pkg::QCNT_W'(ffr_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == ffr_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == ffr_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FFR_ASSERT(a_count_bound, count <= ffr_pkg::QCNT_W'(ffr_pkg::QUEUE_DEPTH), "queue overfilled")
  `FFR_ASSERT_NEXT(a_push_counts, do_push && !do_pop, count == $past(count) + 1'b1, "push lost")

endmodule

[rtl/core/ffr_back.sv]
`include "assert_macros.svh"

module ffr_back (
  input  logic                clk,
  input  logic                rst,
  input  ffr_pkg::cmd_beat_t  head,
  output logic                pop,
  ffr_out_if.source           res
);

  ffr_pkg::back_state_t          state;
  ffr_pkg::back_state_t          state_next;
  ffr_pkg::mode_t                mode;
  ffr_pkg::cmd_t                 cur;

  logic [ffr_pkg::LEVEL_W-1:0]   levels [ffr_pkg::NUM_LINES];
  logic [ffr_pkg::FACTOR_W-1:0]  factor;
  logic [ffr_pkg::FACTOR_W-1:0]  step;
  logic [ffr_pkg::PROD_W-1:0]    prod;
  logic [ffr_pkg::DUR_W-1:0]     rem;
  logic [ffr_pkg::FACTOR_W-1:0]  quo;
  logic [ffr_pkg::DCNT_W-1:0]    bitcnt;
  ffr_pkg::line_idx_t            idx;

  logic                          res_valid;
  logic [ffr_pkg::LINE_W-1:0]    res_line;
  logic [ffr_pkg::LEVEL_W-1:0]   res_level;
  logic                          res_last;

  logic                          out_free;
  logic                          send;
  logic                          send_last;
  logic [ffr_pkg::DUR_W:0]       shifted;
  logic                          ge;
  logic [ffr_pkg::FACTOR_W-1:0]  quo_next;
  logic [ffr_pkg::ACC_W-1:0]     sum_up;
  logic                          clamp_in;
  logic                          ended_in;

  assign out_free  = !res_valid || res.ready;
  assign send_last = (cur.func == ffr_pkg::FUNC_SET) ||
                     (idx == ffr_pkg::line_idx_t'(ffr_pkg::NUM_LINES - 1));

  // One restoring division step per cycle; the dividend is unity, so only
  // its top bit is ever shifted in.
  always_comb begin
    shifted  = {rem, bitcnt == ffr_pkg::DCNT_W'(ffr_pkg::FACTOR_W - 1)};
    ge       = shifted >= {1'b0, cur.duration};
    quo_next = {quo[ffr_pkg::FACTOR_W-2:0], ge};
    sum_up   = {1'b0, prod} + ffr_pkg::ACC_W'(factor);
  end

  assign clamp_in = (state == ffr_pkg::B_ACC) && (mode == ffr_pkg::MODE_IN) &&
                    (sum_up >= ffr_pkg::ACC_W'(ffr_pkg::UNITY_Q24));
  assign ended_in = (mode == ffr_pkg::MODE_IDLE) && (factor == ffr_pkg::UNITY_Q24);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    send       = 1'b0;
    case (state)
      ffr_pkg::B_FETCH: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.func)
            ffr_pkg::FUNC_SET:      state_next = ffr_pkg::B_SCALE;
            ffr_pkg::FUNC_FADE_IN,
            ffr_pkg::FUNC_FADE_OUT: state_next = ffr_pkg::B_DIV;
            default: begin
              state_next = (mode == ffr_pkg::MODE_IDLE) ? ffr_pkg::B_FETCH : ffr_pkg::B_MUL;
            end
          endcase
        end
      end
      ffr_pkg::B_DIV: begin
        if (bitcnt == '0) begin
          state_next = ffr_pkg::B_FETCH;
        end
      end
      ffr_pkg::B_MUL:   state_next = ffr_pkg::B_ACC;
      ffr_pkg::B_ACC:   state_next = ffr_pkg::B_SCALE;
      ffr_pkg::B_SCALE: state_next = ffr_pkg::B_SEND;
      ffr_pkg::B_SEND: begin
        if (out_free) begin
          send       = 1'b1;
          state_next = send_last ? ffr_pkg::B_FETCH : ffr_pkg::B_SCALE;
        end
      end
      default: state_next = ffr_pkg::B_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffr_pkg::B_FETCH;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= ffr_pkg::MODE_IDLE;
      factor <= ffr_pkg::UNITY_Q24;
      step   <= ffr_pkg::UNITY_Q24;
      for (int i = 0; i < ffr_pkg::NUM_LINES; i++) begin
        levels[i] <= ffr_pkg::UNITY_Q15;
      end
    end else begin
      if (pop) begin
        case (head.cmd.func)
          ffr_pkg::FUNC_SET: begin
            levels[ffr_pkg::line_idx_t'(head.cmd.line)] <= head.cmd.level;
          end
          ffr_pkg::FUNC_FADE_IN: begin
            mode   <= ffr_pkg::MODE_IN;
            factor <= '0;
          end
          ffr_pkg::FUNC_FADE_OUT: begin
            mode   <= ffr_pkg::MODE_OUT;
            factor <= ffr_pkg::UNITY_Q24;
          end
          default: begin
          end
        endcase
      end
      if (state == ffr_pkg::B_DIV && bitcnt == '0) begin
        step <= quo_next;
      end
      if (state == ffr_pkg::B_ACC) begin
        if (mode == ffr_pkg::MODE_IN) begin
          if (sum_up >= ffr_pkg::ACC_W'(ffr_pkg::UNITY_Q24)) begin
            factor <= ffr_pkg::UNITY_Q24;
            mode   <= ffr_pkg::MODE_IDLE;
          end else begin
            factor <= sum_up[ffr_pkg::FACTOR_W-1:0];
          end
        end else begin
          if (prod >= ffr_pkg::PROD_W'(factor)) begin
            factor <= '0;
            mode   <= ffr_pkg::MODE_IDLE;
          end else begin
            factor <= factor - prod[ffr_pkg::FACTOR_W-1:0];
          end
        end
      end
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= head.cmd;
      idx    <= ffr_pkg::line_idx_t'(head.cmd.line);
      rem    <= '0;
      quo    <= '0;
      bitcnt <= ffr_pkg::DCNT_W'(ffr_pkg::FACTOR_W - 1);
    end
    case (state)
      ffr_pkg::B_DIV: begin
        rem    <= ge ? ffr_pkg::DUR_W'(shifted - {1'b0, cur.duration})
                     : shifted[ffr_pkg::DUR_W-1:0];
        quo    <= quo_next;
        bitcnt <= bitcnt - 1'b1;
      end
      ffr_pkg::B_MUL: begin
        prod <= ffr_pkg::PROD_W'(step) * ffr_pkg::PROD_W'(cur.delta);
      end
      ffr_pkg::B_ACC: begin
        idx <= '0;
      end
      ffr_pkg::B_SCALE: begin
        prod <= ffr_pkg::PROD_W'(levels[idx]) * ffr_pkg::PROD_W'(factor);
      end
      ffr_pkg::B_SEND: begin
        if (send && !send_last) begin
          idx <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (send) begin
      res_line  <= ffr_pkg::LINE_W'(idx);
      res_level <= prod[ffr_pkg::LEVEL_W+ffr_pkg::FACTOR_W-2:ffr_pkg::FACTOR_W-1];
      res_last  <= send_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (send) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign res.valid     = res_valid;
  assign res.out_line  = res_line;
  assign res.out_level = res_level;
  assign res.last      = res_last;

  `FFR_ASSERT(a_factor_bound, factor <= ffr_pkg::UNITY_Q24, "fade factor above unity")
  `FFR_ASSERT(a_line_range, !res_valid || 32'(res_line) < 32'(ffr_pkg::NUM_LINES), "bad line")
  `FFR_ASSERT_NEXT(a_idle_after_clamp, clamp_in, ended_in, "fade in did not end at unity")

endmodule

[sim/testbench.sv]
module testbench;
  import ffr_pkg::*;

  localparam int ITEMS      = 370;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_LEN  = 80;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    func_t              func;
    logic [LINE_W-1:0]  line;
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   duration;
    logic [DELTA_W-1:0] delta;
  } fade_cmd_t;

  typedef struct {
    logic [LINE_W-1:0]  line;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } line_level_t;

  // Tracks the line levels and the fade ramp, and holds the levels still owed on res.
  class fade_scoreboard;
    logic [LEVEL_W-1:0] user_level [NUM_LINES];
    longint             factor;
    longint             step;
    mode_t              mode;
    line_level_t        owed_q [$];
    int                 errors;
    int                 accepted;
    int                 useful;
    int                 checked;
    int                 fades;
    int                 ramp_ticks;

    function new();
      for (int i = 0; i < NUM_LINES; i++) user_level[i] = UNITY_Q15;
      factor = longint'(UNITY_Q24);
      step   = longint'(UNITY_Q24);
      mode   = MODE_IDLE;
    endfunction

    function longint step_size(logic [DUR_W-1:0] dur);
      longint d;
      d = (dur == 0) ? 1 : longint'(dur);
      return longint'(UNITY_Q24) / d;
    endfunction

    function logic [LEVEL_W-1:0] faded(logic [LEVEL_W-1:0] lvl);
      longint unsigned p;
      p = longint'(lvl) * factor;
      return LEVEL_W'(p >> 24);
    endfunction

    function void owe(int ln, logic lst);
      line_level_t r;
      r.line  = LINE_W'(ln);
      r.level = faded(user_level[ln]);
      r.last  = lst;
      owed_q.push_back(r);
    endfunction

    function void note(fade_cmd_t c);
      logic [LEVEL_W-1:0] lvl;
      accepted++;
      case (c.func)
        FUNC_SET: begin
          if (c.line < NUM_LINES) begin
            lvl = (c.level > UNITY_Q15) ? UNITY_Q15 : c.level;
            user_level[c.line] = lvl;
            owe(c.line, 1'b1);
            useful++;
          end
        end
        FUNC_FADE_IN: begin
          factor = 0;
          step   = step_size(c.duration);
          mode   = MODE_IN;
          fades++;
          useful++;
        end
        FUNC_FADE_OUT: begin
          factor = longint'(UNITY_Q24);
          step   = -step_size(c.duration);
          mode   = MODE_OUT;
          fades++;
          useful++;
        end
        default: begin
          if (mode != MODE_IDLE) begin
            factor += step * longint'(c.delta);
            if (mode == MODE_IN && factor >= longint'(UNITY_Q24)) begin
              factor = longint'(UNITY_Q24);
              mode   = MODE_IDLE;
            end else if (mode == MODE_OUT && factor <= 0) begin
              factor = 0;
              mode   = MODE_IDLE;
            end
            for (int i = 0; i < NUM_LINES; i++) owe(i, i == NUM_LINES - 1);
            ramp_ticks++;
            useful++;
          end
        end
      endcase
    endfunction

    function void check(logic [LINE_W-1:0] ln, logic [LEVEL_W-1:0] lvl, logic lst);
      line_level_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected beat line %0d level %0d last %0b", $time, ln, lvl, lst);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (ln !== want.line || lvl !== want.level || lst !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch, expected line %0d level %0d last %0b, got %0d %0d %0b",
                   $time, want.line, want.level, want.last, ln, lvl, lst);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ffr_in_if  cmd_ch ();
  ffr_out_if res_ch ();

  multi_line_volume_fade_ramp_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  fade_scoreboard sb = new();
  int  idle_pct;
  int  stall_pct;
  bit  hold_request;
  int  hold_left;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    fade_cmd_t c;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c.func     = func_t'(cmd_ch.func);
      c.line     = cmd_ch.line;
      c.level    = cmd_ch.level;
      c.duration = cmd_ch.duration;
      c.delta    = cmd_ch.delta;
      sb.note(c);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check(res_ch.out_line, res_ch.out_level, res_ch.last);
  end

  // The receiver runs on its own; a long hold-off lets the command queue fill up.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_cmd(func_t f, int ln, int lvl, int dur, int dt);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= f;
    cmd_ch.line     <= LINE_W'(ln);
    cmd_ch.level    <= LEVEL_W'(lvl);
    cmd_ch.duration <= DUR_W'(dur);
    cmd_ch.delta    <= DELTA_W'(dt);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  function automatic int pick_level();
    return ($urandom_range(99) < 8) ? $urandom_range(32769, 65535) : $urandom_range(0, 32768);
  endfunction

  // A fade start followed by a run of ticks, with level writes mixed in.
  task automatic ramp_burst();
    func_t f;
    int    r;
    int    dur;
    int    n;
    f = $urandom_range(1) ? FUNC_FADE_IN : FUNC_FADE_OUT;
    r = $urandom_range(99);
    dur = (r < 70) ? $urandom_range(1, 40) :
          (r < 90) ? $urandom_range(41, 2000) : $urandom_range(0, 65535);
    send_cmd(f, $urandom_range(0, 7), $urandom_range(0, 65535), dur, $urandom_range(0, 65535));
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(99) < 25)
        send_cmd(FUNC_SET, $urandom_range(0, NUM_LINES - 1), pick_level(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      send_cmd(FUNC_TICK, $urandom_range(0, 7), $urandom_range(0, 65535),
               $urandom_range(0, 65535),
               ($urandom_range(99) < 90) ? $urandom_range(0, dur / 3 + 1)
                                         : $urandom_range(0, 65535));
    end
  endtask

  task automatic noise_cmd();
    send_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  initial begin
    rst             <= 1'b1;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.func     <= FUNC_SET;
    cmd_ch.line     <= '0;
    cmd_ch.level    <= '0;
    cmd_ch.duration <= '0;
    cmd_ch.delta    <= '0;
    idle_pct        = 0;
    stall_pct       = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, level extremes and saturation, lines out of range,
    // zero and maximum durations, clamping, and a fade restarted mid-ramp.
    send_cmd(FUNC_TICK, 0, 0, 0, 65535);
    send_cmd(FUNC_SET, 0, 0, 0, 0);
    send_cmd(FUNC_SET, 1, 32768, 0, 0);
    send_cmd(FUNC_SET, 2, 65535, 0, 0);
    send_cmd(FUNC_SET, 3, 1, 0, 0);
    send_cmd(FUNC_SET, 4, 32767, 0, 0);
    send_cmd(FUNC_SET, 5, 1000, 0, 0);
    send_cmd(FUNC_SET, 7, 12345, 0, 0);
    send_cmd(FUNC_FADE_OUT, 0, 0, 0, 0);
    send_cmd(FUNC_TICK, 0, 0, 0, 0);
    send_cmd(FUNC_TICK, 0, 0, 0, 1);
    send_cmd(FUNC_TICK, 0, 0, 0, 1);
    send_cmd(FUNC_FADE_IN, 0, 0, 65535, 0);
    send_cmd(FUNC_TICK, 0, 0, 0, 65535);
    send_cmd(FUNC_TICK, 0, 0, 0, 1);
    send_cmd(FUNC_FADE_IN, 0, 0, 3, 0);
    send_cmd(FUNC_TICK, 0, 0, 0, 1);
    send_cmd(FUNC_FADE_OUT, 0, 0, 2, 0);
    send_cmd(FUNC_TICK, 0, 0, 0, 1);
    send_cmd(FUNC_SET, 2, 20000, 0, 0);
    send_cmd(FUNC_TICK, 0, 0, 0, 1);
    send_cmd(FUNC_FADE_IN, 0, 0, 1, 0);
    send_cmd(FUNC_TICK, 7, 65535, 65535, 65535);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      while (sb.accepted < (ph + 1) * ITEMS / 4) begin
        if ($urandom_range(99) < 80) ramp_burst();
        else noise_cmd();
      end
    end
    cmd_ch.valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    $display("%0d commands taken, %0d with an effect (%0d fade starts, %0d ramp ticks)",
             sb.accepted, sb.useful, sb.fades, sb.ramp_ticks);
    $display("%0d beats checked; idle mixes: none, sender only, receiver only, both;",
             sb.checked);
    $display("one long receiver hold-off with the sender still offering commands");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
